// ===== sv/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile pixel renderer package
// Shared constants, command codes and pipeline types for the tile renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tpr_pkg;

  // Video memory: bytes, and the four plane bytes of one tile row as a word.
  localparam int unsigned VIDEO_DEPTH = 16384;
  localparam int unsigned PLANES      = 4;
  localparam int unsigned VIDEO_WORDS = VIDEO_DEPTH / PLANES;
  localparam int unsigned VIDEO_AW    = $clog2(VIDEO_WORDS);

  // Colour memory: 32 entries of 2-bit red, green and blue fields.
  localparam int unsigned COLOUR_DEPTH = 32;
  localparam int unsigned COLOUR_AW    = $clog2(COLOUR_DEPTH);
  localparam int unsigned COLOUR_W     = 6;

  localparam int unsigned SCREEN_ROWS_DEF = 224;
  localparam int unsigned TILE_PIXELS     = 64;
  localparam int unsigned PIX_CNT_W       = $clog2(TILE_PIXELS);

  typedef enum logic [1:0] {
    ACT_VIDEO_WR  = 2'd0,
    ACT_COLOUR_WR = 2'd1,
    ACT_DRAW      = 2'd2
  } tpr_action_e;

  // First stage: screen position and what the plane decode still needs.
  typedef struct packed {
    logic       valid;
    logic [9:0] px;
    logic [9:0] py;
    logic [2:0] col;
    logic       hflip;
    logic       sprite;
    logic       dbl;
    logic       wrap;
    logic       last;
  } tpr_s1_t;

  // Second stage: final position, visibility and the colour entry to read.
  typedef struct packed {
    logic                 valid;
    logic [9:0]           px;
    logic [9:0]           py;
    logic [1:0]           size;
    logic                 vis;
    logic [COLOUR_AW-1:0] caddr;
    logic                 last;
  } tpr_s2_t;

  // A 2-bit level times 85 is the field repeated four times.
  function automatic logic [7:0] level(input logic [1:0] f);
    level = {f, f, f, f};
  endfunction

endpackage

`default_nettype wire

// ===== sv/tpr_if.sv =====
// ----------------------------------------------------------------------------
// Tile pixel renderer channel interfaces
// Command channel into the renderer and pixel channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [13:0] mem_address;
  logic [7:0] mem_data;
  logic [8:0] tile_index;
  logic [8:0] tile_x;
  logic [8:0] tile_y;
  logic       flip_horizontal;
  logic       flip_vertical;
  logic       sprite_palette;
  logic       double_scale;
  logic       wrap_rows;

  modport source (
    output valid, action, mem_address, mem_data, tile_index, tile_x, tile_y,
           flip_horizontal, flip_vertical, sprite_palette, double_scale, wrap_rows,
    input  ready
  );
  modport sink (
    input  valid, action, mem_address, mem_data, tile_index, tile_x, tile_y,
           flip_horizontal, flip_vertical, sprite_palette, double_scale, wrap_rows,
    output ready
  );
endinterface

interface tpr_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [1:0] pixel_size;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       visible;
  logic       last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_size, red, green, blue, visible, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_size, red, green, blue, visible, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/tile_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// Tile pixel renderer
// The first pixel of a draw passes the sequencer, stage 1, stage 2 and the
// output register before it is valid. One pixel per cycle while the sink
// takes pixels; the next command waits until the last pixel has left stage 2.
// Reset clears the colour memory at once and then sweeps all 4096 words of the
// video memory, one 32-bit row word per cycle, before the first command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_pixel_renderer #(
  parameter int unsigned SCREEN_ROWS = tpr_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tpr_cmd_if.sink        cmd_i,
  tpr_pix_if.source      pix_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_data_i
);

  localparam logic [9:0] WRAP_ROWS = 10'(SCREEN_ROWS);

  // --------------------------------------------------------------------------
  // Storage. The video memory is organized as one word per tile row: the four
  // plane bytes of a row sit at consecutive byte addresses, aligned to four,
  // so a single read returns all planes of the row. Byte writes use the low
  // two address bits as lane select.
  // --------------------------------------------------------------------------
  logic [tpr_pkg::PLANES-1:0][7:0] vmem_q [tpr_pkg::VIDEO_WORDS];
  logic [tpr_pkg::COLOUR_W-1:0]    cmem_q [tpr_pkg::COLOUR_DEPTH];
  logic                            hide_left_q;

  // Clear sweep counter; the top bit set means the sweep is done.
  logic [tpr_pkg::VIDEO_AW:0] clr_cnt_q;
  logic                       clr_done;
  assign clr_done = clr_cnt_q[tpr_pkg::VIDEO_AW];

  // Draw sequencer state, loaded on a draw transfer.
  logic                         busy_q;
  logic [tpr_pkg::PIX_CNT_W-1:0] cnt_q;
  logic [8:0]                   tile_q;
  logic [8:0]                   tx_q;
  logic [8:0]                   ty_q;
  logic                         hflip_q;
  logic                         vflip_q;
  logic                         sprite_q;
  logic                         dbl_q;
  logic                         wrap_q;

  tpr_pkg::tpr_s1_t             s1_q, s1_d;
  tpr_pkg::tpr_s2_t             s2_q, s2_d;
  logic [tpr_pkg::PLANES-1:0][7:0] rdata_q;

  logic       out_valid_q;
  logic [9:0] out_x_q, out_y_q;
  logic [1:0] out_size_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;
  logic       out_vis_q;
  logic       out_last_q;

  // The whole pipeline moves together; it holds when the output register is
  // full and the sink is not taking the pixel.
  logic adv;
  assign adv = !out_valid_q || pix_o.ready;

  // A command is taken only when the sequencer is idle and no pixel is still
  // ahead of the colour lookup, so writes never race reads in flight.
  logic cmd_xfer;
  assign cmd_i.ready = clr_done && !busy_q && !s1_q.valid && !s2_q.valid;
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  logic is_vwr, is_cwr, is_draw;
  always_comb begin
    is_vwr  = 1'b0;
    is_cwr  = 1'b0;
    is_draw = 1'b0;
    case (tpr_pkg::tpr_action_e'(cmd_i.action))
      tpr_pkg::ACT_VIDEO_WR:  is_vwr  = 1'b1;
      tpr_pkg::ACT_COLOUR_WR: is_cwr  = 1'b1;
      tpr_pkg::ACT_DRAW:      is_draw = 1'b1;
      default: ; // the unused code is taken and dropped
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hide_left_q <= 1'b0;
    end else if (cfg_we_i) begin
      hide_left_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Video memory write port, shared by the clear sweep and byte writes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (!clr_done) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  logic [tpr_pkg::VIDEO_AW-1:0] vw_addr;
  logic [tpr_pkg::PLANES-1:0]   vw_be;
  logic [7:0]                   vw_data;
  always_comb begin
    if (!clr_done) begin
      vw_addr = clr_cnt_q[tpr_pkg::VIDEO_AW-1:0];
      vw_be   = '1;
      vw_data = '0;
    end else begin
      vw_addr = cmd_i.mem_address[13:2];
      vw_be   = '0;
      vw_be[cmd_i.mem_address[1:0]] = cmd_xfer && is_vwr;
      vw_data = cmd_i.mem_data;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < tpr_pkg::PLANES; l++) begin
      if (vw_be[l]) begin
        vmem_q[vw_addr][l] <= vw_data;
      end
    end
  end

  // Colour memory: small enough for flip-flops cleared directly by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < tpr_pkg::COLOUR_DEPTH; e++) begin
        cmem_q[e] <= '0;
      end
    end else if (cmd_xfer && is_cwr) begin
      cmem_q[cmd_i.mem_address[tpr_pkg::COLOUR_AW-1:0]] <=
        cmd_i.mem_data[tpr_pkg::COLOUR_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: walks the 64 pixels in display order, row then column.
  // --------------------------------------------------------------------------
  logic [2:0] seq_row, seq_col, src_row;
  logic       seq_last;
  assign seq_row  = cnt_q[5:3];
  assign seq_col  = cnt_q[2:0];
  assign src_row  = vflip_q ? ~seq_row : seq_row;
  assign seq_last = (cnt_q == tpr_pkg::PIX_CNT_W'(tpr_pkg::TILE_PIXELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_xfer && is_draw) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && adv) begin
      cnt_q <= cnt_q + 1'b1;
      if (seq_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_xfer && is_draw) begin
      tile_q   <= cmd_i.tile_index;
      tx_q     <= cmd_i.tile_x;
      ty_q     <= cmd_i.tile_y;
      hflip_q  <= cmd_i.flip_horizontal;
      vflip_q  <= cmd_i.flip_vertical;
      sprite_q <= cmd_i.sprite_palette;
      dbl_q    <= cmd_i.double_scale;
      wrap_q   <= cmd_i.wrap_rows;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: row read from video memory and raw screen position.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_d.valid  = busy_q;
    s1_d.px     = {1'b0, tx_q} + (dbl_q ? {6'd0, seq_col, 1'b0} : {7'd0, seq_col});
    s1_d.py     = {1'b0, ty_q} + (dbl_q ? {6'd0, seq_row, 1'b0} : {7'd0, seq_row});
    s1_d.col    = seq_col;
    s1_d.hflip  = hflip_q;
    s1_d.sprite = sprite_q;
    s1_d.dbl    = dbl_q;
    s1_d.wrap   = wrap_q;
    s1_d.last   = seq_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= vmem_q[{tile_q, src_row}];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: plane decode into a 4-bit index, row wrap and visibility.
  // The leftmost column takes bit 7 of each plane unless mirrored.
  // --------------------------------------------------------------------------
  logic [2:0]                bit_sel;
  logic [tpr_pkg::PLANES-1:0] idx;
  always_comb begin
    bit_sel = s1_q.hflip ? s1_q.col : ~s1_q.col;
    for (int p = 0; p < tpr_pkg::PLANES; p++) begin
      idx[p] = rdata_q[p][bit_sel];
    end
    s2_d.valid = s1_q.valid;
    s2_d.px    = s1_q.px;
    s2_d.py    = (s1_q.wrap && (s1_q.py >= WRAP_ROWS)) ? (s1_q.py - WRAP_ROWS) : s1_q.py;
    s2_d.size  = s1_q.dbl ? 2'd2 : 2'd1;
    s2_d.vis   = (idx != '0) && !(hide_left_q && (s1_q.px < 10'd8));
    s2_d.caddr = {s1_q.sprite, idx};
    s2_d.last  = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv) begin
      s2_q <= s2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: colour lookup and level expansion into the output register.
  // Hidden and transparent pixels report black.
  // --------------------------------------------------------------------------
  logic [tpr_pkg::COLOUR_W-1:0] colour;
  assign colour = s2_q.vis ? cmem_q[s2_q.caddr] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q    <= s2_q.px;
      out_y_q    <= s2_q.py;
      out_size_q <= s2_q.size;
      out_r_q    <= tpr_pkg::level(colour[1:0]);
      out_g_q    <= tpr_pkg::level(colour[3:2]);
      out_b_q    <= tpr_pkg::level(colour[5:4]);
      out_vis_q  <= s2_q.vis;
      out_last_q <= s2_q.last;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_x    = out_x_q;
  assign pix_o.pixel_y    = out_y_q;
  assign pix_o.pixel_size = out_size_q;
  assign pix_o.red        = out_r_q;
  assign pix_o.green      = out_g_q;
  assign pix_o.blue       = out_b_q;
  assign pix_o.visible    = out_vis_q;
  assign pix_o.last       = out_last_q;

`ifndef SYNTH
  // A draw transfer restarts the sequencer at the first pixel.
  a_draw_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_xfer && is_draw) |=> (busy_q && (cnt_q == '0)))
    else $error("sequencer did not restart on a draw");

  // While the pipeline holds, the sequencer must not skip a pixel.
  a_seq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !adv) |=> $stable(cnt_q))
    else $error("sequencer advanced during a stall");

  // Once the last pixel is past the sequencer, no new draw may be running.
  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((s1_q.valid && s1_q.last) || (s2_q.valid && s2_q.last)) |-> !busy_q)
    else $error("draw started before the previous one drained");

  // A pixel that is not drawn carries no colour.
  a_hidden_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_vis_q) |-> ((out_r_q == '0) && (out_g_q == '0) && (out_b_q == '0)))
    else $error("hidden pixel carries colour");
`endif

endmodule

`default_nettype wire
